@@ design/bitset_triangle_lister_macros.svh @@
// ----------------------------------------------------------------------------
// bitset_triangle_lister_macros.svh
// Assertion macros shared by the triangle lister checks.
// ----------------------------------------------------------------------------
`ifndef BITSET_TRIANGLE_LISTER_MACROS_SVH
`define BITSET_TRIANGLE_LISTER_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define BTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define BTL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

@@ design/btl_pkg.sv @@
// ----------------------------------------------------------------------------
// btl_pkg
// Types, constants and bit helpers for the bitset triangle lister.
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int unsigned ROW_W  = 32;
  localparam int unsigned VTX_W  = 5;
  localparam int unsigned CNT_W  = 6;

  localparam logic [ROW_W-1:0] TOP_BIT  = 32'h8000_0000;
  localparam logic [ROW_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_RDI  = 5'b00100,
    ST_RDJ  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Vertex 0 sits in the top bit.
  function automatic row_t vertex_bit(input vtx_t v);
    return TOP_BIT >> v;
  endfunction

  // Bits of the first n vertices; n of 32 or more gives all ones.
  function automatic row_t lead_mask(input cnt_t n);
    return ~(ALL_ONES >> n);
  endfunction

  // Lowest-numbered vertex set in a nonzero mask.
  function automatic vtx_t first_vertex(input row_t mask);
    vtx_t k;
    k = '0;
    for (int v = ROW_W - 1; v >= 0; v--) begin
      if (mask[ROW_W-1-v]) begin
        k = VTX_W'(v);
      end
    end
    return k;
  endfunction

endpackage

@@ design/bitset_triangle_lister.sv @@
// A load item's result (an empty ack) passes through ST_EMIT into the output register.
// A fetch item first runs its scan, which takes a step for each (i, j) pair visited, a row j
// read (ST_RDJ) when j is a neighbor of i, and an advance and a row i read (ST_RDI) per new i;
// the result then passes through ST_EMIT into the output register.
// Throughput: one item at a time; input reopens once the result enters the output register.
// Reset: cursors restart, vertex_count = 32, adjacency rows hold garbage until loaded.
// ----------------------------------------------------------------------------
// bitset_triangle_lister
// Streams the triangles of a graph held as bitset rows in a simple dual-port RAM.
// ----------------------------------------------------------------------------
module bitset_triangle_lister #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  btl_pkg::vtx_t        in_row_index,
  input  btl_pkg::row_t        in_row_bits,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output btl_pkg::vtx_t        out_first_vertex,
  output btl_pkg::vtx_t        out_second_vertex,
  output btl_pkg::vtx_t        out_third_vertex,
  // register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  btl_pkg::cnt_t        cfg_vertex_count
);
  import btl_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam cnt_t MAX_CNT = CNT_W'(MAX_VERTICES);

  // adjacency RAM
  row_t            adj_mem [MAX_VERTICES];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  row_t            rd_data_r;

  state_t state_r,   state_nxt;
  cnt_t   vc_r,      vc_nxt;
  cnt_t   outer_r,   outer_nxt;
  cnt_t   inner_r,   inner_nxt;
  row_t   pend_r,    pend_nxt;
  row_t   row_i_r,   row_i_nxt;
  logic   row_ok_r,  row_ok_nxt;

  // result being built, waits in ST_EMIT for the output register
  logic   res_found_r, res_found_nxt;
  vtx_t   res_i_r,     res_i_nxt;
  vtx_t   res_j_r,     res_j_nxt;
  vtx_t   res_k_r,     res_k_nxt;

  logic   out_valid_r;
  logic   out_found_r;
  vtx_t   out_i_r, out_j_r, out_k_r;

  logic   in_acc, cfg_acc, out_load;
  cnt_t   vc_used;
  row_t   all_n;
  vtx_t   k_pick;

  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  // a pending register write wins over an item
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;

  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  assign vc_used   = (vc_r > MAX_CNT) ? MAX_CNT : vc_r;
  assign all_n     = lead_mask(vc_used);
  assign k_pick    = first_vertex(pend_r);

  assign mem_we    = in_acc && (in_mode == MODE_LOAD) && (CNT_W'(in_row_index) < MAX_CNT);
  assign mem_waddr = in_row_index[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    pend_nxt      = pend_r;
    row_i_nxt     = row_i_r;
    row_ok_nxt    = row_ok_r;
    res_found_nxt = res_found_r;
    res_i_nxt     = res_i_r;
    res_j_nxt     = res_j_r;
    res_k_nxt     = res_k_r;
    mem_raddr     = outer_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          vc_nxt     = cfg_vertex_count;
          outer_nxt  = '0;
          inner_nxt  = CNT_W'(1);
          pend_nxt   = '0;
          row_ok_nxt = 1'b0;
        end else if (in_acc) begin
          if (in_mode == MODE_LOAD) begin
            outer_nxt     = '0;
            inner_nxt     = CNT_W'(1);
            pend_nxt      = '0;
            row_ok_nxt    = 1'b0;
            res_found_nxt = 1'b0;
            res_i_nxt     = '0;
            res_j_nxt     = '0;
            res_k_nxt     = '0;
            state_nxt     = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_r != '0) begin
          pend_nxt      = pend_r & ~vertex_bit(k_pick);
          res_found_nxt = 1'b1;
          res_i_nxt     = outer_r[VTX_W-1:0];
          res_j_nxt     = VTX_W'(inner_r - CNT_W'(1));
          res_k_nxt     = k_pick;
          state_nxt     = ST_EMIT;
        end else if (outer_r >= vc_used) begin
          res_found_nxt = 1'b0;
          res_i_nxt     = '0;
          res_j_nxt     = '0;
          res_k_nxt     = '0;
          state_nxt     = ST_EMIT;
        end else if (inner_r >= vc_used) begin
          outer_nxt  = outer_r + CNT_W'(1);
          inner_nxt  = outer_r + CNT_W'(2);
          row_ok_nxt = 1'b0;
        end else if (!row_ok_r) begin
          mem_raddr = outer_r[AW-1:0];
          state_nxt = ST_RDI;
        end else begin
          inner_nxt = inner_r + CNT_W'(1);
          if ((row_i_r & vertex_bit(inner_r[VTX_W-1:0])) != '0) begin
            mem_raddr = inner_r[AW-1:0];
            state_nxt = ST_RDJ;
          end
        end
      end
      ST_RDI: begin
        row_i_nxt  = rd_data_r;
        row_ok_nxt = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_RDJ: begin
        // inner_r already points one past j: keep only k > j
        pend_nxt  = row_i_r & rd_data_r & all_n & (ALL_ONES >> inner_r);
        state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM: one write port used only while idle, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= in_row_bits;
    end
    rd_data_r <= adj_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= CNT_W'(32);
      outer_r     <= '0;
      inner_r     <= CNT_W'(1);
      pend_r      <= '0;
      row_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vc_r     <= vc_nxt;
      outer_r  <= outer_nxt;
      inner_r  <= inner_nxt;
      pend_r   <= pend_nxt;
      row_ok_r <= row_ok_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_i_r     <= row_i_nxt;
    res_found_r <= res_found_nxt;
    res_i_r     <= res_i_nxt;
    res_j_r     <= res_j_nxt;
    res_k_r     <= res_k_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_i_r     <= res_i_r;
      out_j_r     <= res_j_r;
      out_k_r     <= res_k_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_first_vertex  = out_i_r;
  assign out_second_vertex = out_j_r;
  assign out_third_vertex  = out_k_r;

endmodule

@@ design/btl_checker.sv @@
// ----------------------------------------------------------------------------
// btl_checker
// Port-level checks on the bitset triangle lister, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitset_triangle_lister_macros.svh"

module btl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_found,
  input btl_pkg::vtx_t        out_first_vertex,
  input btl_pkg::vtx_t        out_second_vertex,
  input btl_pkg::vtx_t        out_third_vertex
);

  // a held result keeps its contents
  `BTL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_first_vertex) && $stable(out_second_vertex) && $stable(out_third_vertex), "result changed while stalled")

  // a triangle is always listed in ascending vertex order
  `BTL_ASSERT(a_tri_order, out_valid && out_found |-> (out_first_vertex < out_second_vertex) && (out_second_vertex < out_third_vertex), "triangle vertices out of order")

  // acks and empty answers carry zero vertices
  `BTL_ASSERT(a_empty_zero, out_valid && !out_found |-> (out_first_vertex == 0) && (out_second_vertex == 0) && (out_third_vertex == 0), "nonzero vertex on empty result")

  // one item at a time: an accepted item closes the input
  `BTL_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind bitset_triangle_lister btl_checker u_btl_checker (.*);
